@@ src/trhm_pkg.sv @@
// Package for the touch region hit matcher: region record type, command codes,
// sizing constants and the region containment test. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trhm_pkg;

  // Table depth; sizes the region store, its index and the fill count.
  localparam int unsigned MaxRegions = 64;
  localparam int unsigned AddrW      = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CountW     = $clog2(MaxRegions + 1);

  // Command field codes.
  localparam logic CmdSample   = 1'b0;
  localparam logic CmdRegister = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  // One stored region, 44 bits.
  typedef struct packed {
    logic [8:0] left;
    logic [8:0] right;
    logic [7:0] lower;
    logic [7:0] upper;
    logic [1:0] screen;
    logic [7:0] tag;
  } region_t;

  // Inclusive bounds; an inverted region never matches.
  function automatic logic region_match(input region_t r, input logic [8:0] x,
                                        input logic [7:0] y, input logic [1:0] scr);
    return (r.left <= x) && (r.right >= x) && (r.lower >= y) && (r.upper <= y) &&
           (r.screen == scr);
  endfunction

endpackage

`default_nettype wire

@@ src/trhm_region_store.sv @@
// Region store of the touch region hit matcher: one write port, one read port
// with registered read data. Depends on trhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trhm_region_store
  import trhm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire region_t          wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output region_t               rd_data_o
);

  region_t mem [MaxRegions];
  region_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ src/touch_region_hit_matcher.sv @@
// Top level of the touch region hit matcher: command decode, scan sequencer,
// pending-hit hold and result register. Depends on trhm_pkg, trhm_region_store.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// input    in         in_valid_i/in_ready_o  cmd, touch and region fields
// result   out        out_valid_o/out_ready_i hit_tag, hit_x, hit_y, hit_pressure, last_hit
//
// A register item or a sample that starts no press leaves the sequencer idle.
// A new press is accepted, then one stored region per cycle goes through the shared
// compare unit, then the held hit is released; the result side can stall the scan
// and the release. The store gives one read a cycle; that sets the scan rate.
// Reset clears the fill count, the held-press flag and the sequencer; the store
// needs no clearing, as only filled entries are read.
// The result register lets the scan run while a result waits to be taken.

module touch_region_hit_matcher
  import trhm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       cmd_i,
  input  wire logic       touch_detected_i,
  input  wire logic [8:0] touch_x_i,
  input  wire logic [7:0] touch_y_i,
  input  wire logic [7:0] touch_pressure_i,
  input  wire logic [1:0] current_screen_i,
  input  wire logic [8:0] region_left_i,
  input  wire logic [8:0] region_right_i,
  input  wire logic [7:0] region_lower_i,
  input  wire logic [7:0] region_upper_i,
  input  wire logic [1:0] region_screen_i,
  input  wire logic [7:0] region_tag_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      hit_tag_o,
  output logic [8:0]      hit_x_o,
  output logic [7:0]      hit_y_o,
  output logic [7:0]      hit_pressure_o,
  output logic            last_hit_o
);

  state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic              held_q;
  logic [AddrW-1:0]  idx_q;

  // Sample latched for the scan.
  logic [8:0] x_q;
  logic [7:0] y_q;
  logic [7:0] pres_q;
  logic [1:0] scr_q;

  // Hit held back until we know whether another follows.
  logic       pend_v_q;
  logic [7:0] pend_tag_q;

  // Result register.
  logic       out_valid_q;
  logic [7:0] out_tag_q;
  logic [8:0] out_x_q;
  logic [7:0] out_y_q;
  logic [7:0] out_pres_q;
  logic       out_last_q;

  logic             in_accept;
  logic             do_write;
  logic             start_scan;
  logic             hit;
  logic             out_free;
  logic             advance;
  logic             scan_done;
  logic             push;
  logic [AddrW-1:0] rd_addr;
  region_t          wr_region;
  region_t          rd_region;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign do_write   = in_accept && (cmd_i == CmdRegister) &&
                      (count_q < CountW'(MaxRegions));
  assign start_scan = in_accept && (cmd_i == CmdSample) && !held_q &&
                      touch_detected_i && (count_q != '0);

  assign wr_region = '{left:   region_left_i,
                       right:  region_right_i,
                       lower:  region_lower_i,
                       upper:  region_upper_i,
                       screen: region_screen_i,
                       tag:    region_tag_i};

  trhm_region_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (do_write),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (wr_region),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_region)
  );

  // Shared compare unit: one stored region against the latched point per cycle while the scan advances.
  assign hit      = region_match(rd_region, x_q, y_q, scr_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer outputs.
  always_comb begin
    advance   = 1'b0;
    push      = 1'b0;
    scan_done = 1'b0;
    rd_addr   = '0;
    unique case (state_q)
      StIdle: begin
        rd_addr = '0;
      end
      StScan: begin
        // Hold the entry while a second hit waits for a full result register.
        advance   = !(hit && pend_v_q && !out_free);
        push      = hit && pend_v_q && out_free;
        scan_done = advance && ((CountW'(idx_q) + CountW'(1)) == count_q);
        rd_addr   = advance ? (idx_q + AddrW'(1)) : idx_q;
      end
      StFlush: begin
        push = pend_v_q && out_free;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_scan) state_d = StScan;
      StScan:  if (scan_done) state_d = StFlush;
      StFlush: if (!pend_v_q || out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      held_q      <= 1'b0;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_write) begin
        count_q <= count_q + CountW'(1);
      end
      // Track the press: set on a touch, drop on a sample without touch.
      if (in_accept && (cmd_i == CmdSample)) begin
        held_q <= touch_detected_i;
      end
      if (start_scan) begin
        idx_q <= '0;
      end else if (state_q == StScan && advance) begin
        idx_q <= idx_q + AddrW'(1);
      end
      if (state_q == StScan && advance && hit) begin
        pend_v_q <= 1'b1;
      end else if (state_q == StFlush && push) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      x_q    <= touch_x_i;
      y_q    <= touch_y_i;
      pres_q <= touch_pressure_i;
      scr_q  <= current_screen_i;
    end
    if (state_q == StScan && advance && hit) begin
      pend_tag_q <= rd_region.tag;
    end
    if (push) begin
      out_tag_q  <= pend_tag_q;
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_pres_q <= pres_q;
      out_last_q <= (state_q == StFlush);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_tag_o      = out_tag_q;
  assign hit_x_o        = out_x_q;
  assign hit_y_o        = out_y_q;
  assign hit_pressure_o = out_pres_q;
  assign last_hit_o     = out_last_q;

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxRegions))
    else $error("region count beyond table depth");

  // The scan index stays inside the filled part of the store.
  a_idx_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CountW'(idx_q) < count_q))
    else $error("scan index beyond filled entries");

  // Releasing the final hit returns the sequencer to idle with nothing held.
  a_flush_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush && push) |=> (state_q == StIdle && !pend_v_q && out_last_q))
    else $error("final hit not released cleanly");

  // A result is only written into a free result register.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (pend_v_q && (!out_valid_q || out_ready_i)))
    else $error("result overwritten");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking bench for touch_region_hit_matcher: builds a region table, then replays
// presses, held samples and releases against an in-bench region scorer with random stalls.
// Depends on trhm_pkg and the touch_region_hit_matcher RTL.
`timescale 1ns / 1ps

module tb_top;
  import trhm_pkg::*;

  // One input item as driven on the pins; region fields reuse the stored record layout.
  typedef struct packed {
    logic       cmd;
    logic       touch;
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] pressure;
    logic [1:0] screen;
    region_t    region;
  } stim_t;

  // One hit as it should leave the block.
  typedef struct packed {
    logic [7:0] tag;
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] pressure;
    logic       last;
  } hit_t;

  localparam int unsigned HitCap    = 64;     // most hits one press may report
  localparam int unsigned RandItems = 460;    // fewest input items queued for the whole run
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned DrainCycles = 100;  // quiet time after the last hit

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  out_valid;
  logic  out_ready = 1'b0;
  stim_t cur_item = '0;
  logic [7:0] hit_tag;
  logic [8:0] hit_x;
  logic [7:0] hit_y;
  logic [7:0] hit_pressure;
  logic       last_hit;

  stim_t pending_items[$];
  hit_t  hit_expect[$];

  // Scorer state: its own copy of the region table and the held-press flag.
  region_t     scored_table[MaxRegions];
  int unsigned table_fill = 0;
  logic        press_down = 1'b0;

  // Handshake bookkeeping and run statistics.
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned rx_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        tx_burst = 1'b0;
  logic        rx_burst = 1'b0;
  int unsigned items_taken = 0;
  int unsigned hits_checked = 0;
  int unsigned presses_hit = 0;
  int unsigned widest_press = 0;
  int unsigned regs_dropped = 0;
  int unsigned regs_issued = 0;
  int unsigned fail_cnt = 0;

  always #1 clk = ~clk;

  touch_region_hit_matcher u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cur_item.cmd),
    .touch_detected_i (cur_item.touch),
    .touch_x_i        (cur_item.x),
    .touch_y_i        (cur_item.y),
    .touch_pressure_i (cur_item.pressure),
    .current_screen_i (cur_item.screen),
    .region_left_i    (cur_item.region.left),
    .region_right_i   (cur_item.region.right),
    .region_lower_i   (cur_item.region.lower),
    .region_upper_i   (cur_item.region.upper),
    .region_screen_i  (cur_item.region.screen),
    .region_tag_i     (cur_item.region.tag),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .hit_tag_o        (hit_tag),
    .hit_x_o          (hit_x),
    .hit_y_o          (hit_y),
    .hit_pressure_o   (hit_pressure),
    .last_hit_o       (last_hit)
  );

  // Score one accepted item: append a region, track a held press, or queue the hits
  // of a fresh press in table order with the last one marked.
  task automatic score_item(input stim_t s);
    int unsigned n_hits;
    hit_t        h;
    region_t     r;
    n_hits = 0;
    if (s.cmd == CmdRegister) begin
      // A full table drops the write.
      if (table_fill < MaxRegions) begin
        scored_table[table_fill[AddrW-1:0]] = s.region;
        table_fill++;
      end else begin
        regs_dropped++;
      end
    end else if (press_down) begin
      // Held press: nothing reported, a lifted finger ends the press.
      if (!s.touch) press_down = 1'b0;
    end else if (s.touch) begin
      for (int unsigned i = 0; i < table_fill; i++) begin
        r = scored_table[i[AddrW-1:0]];
        if (n_hits < HitCap && s.x >= r.left && s.x <= r.right &&
            s.y >= r.upper && s.y <= r.lower && r.screen == s.screen) begin
          h.tag      = r.tag;
          h.x        = s.x;
          h.y        = s.y;
          h.pressure = s.pressure;
          h.last     = 1'b0;
          hit_expect.push_back(h);
          n_hits++;
        end
      end
      if (n_hits != 0) begin
        hit_expect[hit_expect.size() - 1].last = 1'b1;
        presses_hit++;
        if (n_hits > widest_press) widest_press = n_hits;
      end
      // A press with no match still counts as held.
      press_down = 1'b1;
    end
  endtask

  function automatic stim_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return stim_t'(bits[$bits(stim_t)-1:0]);
  endfunction

  // Unused region fields carry noise, as the block must ignore them on a sample.
  task automatic add_sample(input int unsigned touch, input int unsigned x,
                            input int unsigned y, input int unsigned pressure,
                            input int unsigned screen);
    stim_t s;
    s          = noise_item();
    s.cmd      = CmdSample;
    s.touch    = touch[0];
    s.x        = x[8:0];
    s.y        = y[7:0];
    s.pressure = pressure[7:0];
    s.screen   = screen[1:0];
    pending_items.push_back(s);
  endtask

  // Unused touch fields carry noise on a register item.
  task automatic add_region(input int unsigned left, input int unsigned right,
                            input int unsigned lower, input int unsigned upper,
                            input int unsigned screen, input int unsigned tag);
    stim_t s;
    s               = noise_item();
    s.cmd           = CmdRegister;
    s.region.left   = left[8:0];
    s.region.right  = right[8:0];
    s.region.lower  = lower[7:0];
    s.region.upper  = upper[7:0];
    s.region.screen = screen[1:0];
    s.region.tag    = tag[7:0];
    pending_items.push_back(s);
    regs_issued++;
  endtask

  // Sample both handshakes at the rising edge. Check the result first, then score the
  // item, so that a hit can never be paired with an expectation queued at the same edge.
  always @(posedge clk) begin : scoreboard
    hit_t want;
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (hit_expect.size() == 0) begin
        $error("unexpected hit: tag %0d x %0d y %0d", hit_tag, hit_x, hit_y);
        fail_cnt++;
      end else begin
        want = hit_expect.pop_front();
        hits_checked++;
        if (hit_tag !== want.tag) begin
          $error("hit_tag: expected %0d, got %0d", want.tag, hit_tag);
          fail_cnt++;
        end
        if (hit_x !== want.x) begin
          $error("hit_x: expected %0d, got %0d", want.x, hit_x);
          fail_cnt++;
        end
        if (hit_y !== want.y) begin
          $error("hit_y: expected %0d, got %0d", want.y, hit_y);
          fail_cnt++;
        end
        if (hit_pressure !== want.pressure) begin
          $error("hit_pressure: expected %0d, got %0d", want.pressure, hit_pressure);
          fail_cnt++;
        end
        if (last_hit !== want.last) begin
          $error("last_hit: expected %0d, got %0d", want.last, last_hit);
          fail_cnt++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      score_item(cur_item);
      items_taken++;
    end
  end

  // Sender: hold an offered item until taken, then idle for the drawn gap and offer the
  // next. Burst stretches switch the gaps off now and then.
  always @(negedge clk) begin : item_drive
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        cur_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) tx_burst <= !tx_burst;
        in_gap   <= tx_burst ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall after each taken hit for the drawn count. Once, well into the run,
  // hold off for a long stretch so the block backs up and stalls its input.
  always @(negedge clk) begin : hit_accept
    int unsigned n;
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && out_valid && items_taken >= 200) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (out_taken) begin
        if ($urandom_range(0, 39) == 0) rx_burst <= !rx_burst;
        n = rx_burst ? 0 : $urandom_range(0, 3);
        rx_left   <= n;
        out_ready <= (n == 0);
      end else if (rx_left != 0) begin
        rx_left   <= rx_left - 1;
        out_ready <= (rx_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned kind;
    int unsigned li;
    int unsigned ui;
    int unsigned guard;

    // Directed: presses on an empty table, then extreme and awkward regions.
    add_sample(0, 0, 0, 0, 0);                 // release with nothing held
    add_sample(1, 511, 255, 255, 3);           // press, empty table
    add_sample(1, 511, 255, 255, 3);           // still held
    add_sample(0, 511, 255, 255, 3);           // lift
    add_region(0, 511, 255, 0, 3, 255);        // whole screen
    add_region(511, 511, 255, 255, 3, 0);
    add_region(0, 0, 0, 0, 0, 90);
    add_region(300, 100, 255, 0, 0, 51);       // inverted in x
    add_region(0, 511, 10, 200, 0, 68);        // inverted in y
    add_region(100, 200, 150, 50, 2, 165);
    add_sample(1, 511, 255, 0, 3);             // two hits, corner
    add_region(256, 256, 128, 128, 1, 129);    // registered mid-press
    add_sample(1, 256, 128, 7, 1);             // held, no hit
    add_sample(0, 0, 0, 0, 0);
    add_sample(1, 256, 128, 99, 1);
    add_sample(0, 0, 0, 0, 0);
    add_sample(1, 0, 0, 1, 0);                 // origin point region
    add_sample(0, 0, 0, 0, 0);
    add_sample(1, 200, 100, 2, 0);             // inside both inverted spans
    add_sample(0, 0, 0, 0, 0);
    add_sample(1, 100, 50, 128, 2);            // low corner of a bounded box
    add_sample(0, 0, 0, 0, 0);
    add_sample(1, 201, 150, 3, 2);             // one past its right bound
    add_sample(0, 0, 0, 0, 0);

    // Random: mostly press, maybe hold, lift; fill the table along the way, with many
    // regions around the screen centre so that centre presses give long hit runs.
    while (pending_items.size() < RandItems) begin
      pick = $urandom_range(0, 99);
      if ((pick < 45 && regs_issued < MaxRegions + 8) || pick < 2) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          add_region($urandom_range(0, 256), $urandom_range(256, 511),
                     $urandom_range(128, 255), $urandom_range(0, 128), 0,
                     $urandom_range(0, 255));
        end else if (kind < 8) begin
          li = $urandom_range(0, 511);
          ui = $urandom_range(0, 255);
          add_region(li, (li + $urandom_range(0, 80) > 511) ? 511 : li + $urandom_range(0, 80),
                     (ui + $urandom_range(0, 60) > 255) ? 255 : ui + $urandom_range(0, 60),
                     ui, $urandom_range(0, 3), $urandom_range(0, 255));
        end else begin
          add_region($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 3), $urandom_range(0, 255));
        end
      end else if (pick < 90) begin
        if ($urandom_range(0, 9) < 3)
          add_sample(1, 256, 128, $urandom_range(0, 255), 0);
        else
          add_sample(1, $urandom_range(0, 511), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 3));
        repeat ($urandom_range(0, 2))
          add_sample(1, $urandom_range(0, 511), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 3));
        add_sample(0, $urandom_range(0, 511), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 3));
      end else begin
        // Noise: a stray sample, often a broken sequence.
        add_sample($urandom_range(0, 1), $urandom_range(0, 511), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 3));
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    for (guard = 0; hit_expect.size() != 0 && guard < 50000; guard++) @(posedge clk);
    if (hit_expect.size() != 0) begin
      $error("%0d expected hits never arrived", hit_expect.size());
      fail_cnt++;
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Run: %0d items taken, %0d regions stored, %0d writes dropped on a full table.",
             items_taken, table_fill, regs_dropped);
    $display("Run: %0d hits checked over %0d scoring presses, widest press %0d hits.",
             hits_checked, presses_hit, widest_press);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up well beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
